FILE: sv/stip_pkg.sv
// Package for the string to integer parser: widths, limits, character codes, phase type.
package stip_pkg;

    localparam int CHAR_BITS       = 8;
    localparam int RADIX_BITS      = 6;
    localparam int DIGIT_BITS      = 6;
    localparam int VALUE_BITS      = 64;
    localparam int OUT_VALUE_BITS  = 64;
    localparam int OFFSET_BITS     = 12;
    localparam int MAX_CHARS       = 4095;
    localparam int CFG_INDEX_BITS  = 1;
    localparam int CFG_DATA_BITS   = 6;

    localparam int COUNT_LIMIT_INT = (MAX_CHARS < 4095) ? MAX_CHARS : 4095;
    localparam logic [OFFSET_BITS-1:0] COUNT_LIMIT = OFFSET_BITS'(COUNT_LIMIT_INT);

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_RADIX       = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SIGNED_MODE = 1'd1;

    localparam logic [RADIX_BITS-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_BITS-1:0] RADIX_AUTO  = 6'd0;
    localparam logic [RADIX_BITS-1:0] RADIX_OCT   = 6'd8;
    localparam logic [RADIX_BITS-1:0] RADIX_DEC   = 6'd10;
    localparam logic [RADIX_BITS-1:0] RADIX_HEX   = 6'd16;

    localparam logic [CHAR_BITS-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_BITS-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_BITS-1:0] CH_NL    = 8'h0A;
    localparam logic [CHAR_BITS-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_BITS-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_BITS-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_BITS-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_BITS-1:0] CH_UX    = 8'h58;
    localparam logic [CHAR_BITS-1:0] CH_UZ    = 8'h5A;
    localparam logic [CHAR_BITS-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_BITS-1:0] CH_LX    = 8'h78;
    localparam logic [CHAR_BITS-1:0] CH_LZ    = 8'h7A;

    localparam logic [CHAR_BITS-1:0] ALPHA_OFFSET = 8'd10;

    typedef enum logic [2:0] {
        PH_SPACE,
        PH_FIRST,
        PH_ZERO,
        PH_DIGITS,
        PH_DONE
    } phase_t;

endpackage

FILE: sv/string_to_integer_parser.sv
// Top level of the streaming string to integer parser (strtol style).
//
// Input channel: one character per request (character, end_of_string) under
// in_valid / in_stall. Whitespace, an optional sign, an optional 0x prefix and
// then digits below the radix are parsed; conversion stops at NUL or at the
// first invalid character, later characters are ignored.
// Output channel: one request (value, end_offset) per string, after the
// request marked end_of_string, under out_valid / out_stall.
// Config: cfg_we writes cfg_data to register cfg_index (0 radix, 1 signed_mode);
// the user must use it only while the block is idle; the block does not enforce this.
// Throughput: one character per cycle while in_stall is low, set by the single
// multiply-add by the radix in the parse stage. Path: the final character goes
// from the input register through the parse stage into the pending register,
// then through the sign stage into the output register, which raises out_valid.
// Reset: radix 10, signed mode on, parser at leading whitespace, no requests
// held. A stalled result holds in the output register; one more result waits
// in the sign stage and then in_stall rises only when a final character
// reaches the parse stage with no room behind it.
module string_to_integer_parser (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [stip_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [stip_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [stip_pkg::CHAR_BITS-1:0]      character,
    input  logic                                end_of_string,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [stip_pkg::OUT_VALUE_BITS-1:0] value,
    output logic [stip_pkg::OFFSET_BITS-1:0]    end_offset
);
    import stip_pkg::*;

    // configuration
    logic [RADIX_BITS-1:0]  radix_reg;
    logic                   signed_mode_reg;

    // input register
    logic                   s1_valid_reg;
    logic [CHAR_BITS-1:0]   char_reg;
    logic                   eos_reg;

    // parser state
    phase_t                 phase_reg;
    phase_t                 phase_next;
    logic [VALUE_BITS-1:0]  acc_reg;
    logic [VALUE_BITS-1:0]  acc_next;
    logic                   neg_reg;
    logic                   neg_next;
    logic [RADIX_BITS-1:0]  act_radix_reg;
    logic [RADIX_BITS-1:0]  act_radix_next;
    logic [OFFSET_BITS-1:0] cnt_reg;
    logic [OFFSET_BITS-1:0] cnt_next;

    // pending result and output register
    logic                   pend_valid_reg;
    logic [VALUE_BITS-1:0]  pend_acc_reg;
    logic                   pend_neg_reg;
    logic [OFFSET_BITS-1:0] pend_cnt_reg;
    logic                   out_valid_reg;
    logic [VALUE_BITS-1:0]  value_reg;
    logic [OFFSET_BITS-1:0] offset_reg;

    // handshake
    logic out_free;
    logic pend_go;
    logic pend_free;
    logic s1_go;
    logic in_accept;

    // decode
    logic                   is_blank;
    logic                   is_minus_ok;
    logic                   is_plus;
    logic                   is_x;
    logic                   is_dec;
    logic                   is_lower;
    logic                   is_upper;
    logic [DIGIT_BITS-1:0]  digit;
    logic                   digit_alnum;
    logic                   first_case;
    logic                   auto_or_hex;
    logic                   prefix_zero;
    logic [RADIX_BITS-1:0]  first_radix;
    logic [RADIX_BITS-1:0]  use_radix;
    logic                   do_digit;
    logic                   digit_ok;
    logic                   count_inc;
    logic [VALUE_BITS-1:0]  acc_step;
    logic [OFFSET_BITS-1:0] cnt_inc;

    assign out_free  = !out_valid_reg || !out_stall;
    assign pend_go   = pend_valid_reg && out_free;
    assign pend_free = !pend_valid_reg || pend_go;
    assign s1_go     = s1_valid_reg && (!eos_reg || pend_free);
    assign in_stall  = s1_valid_reg && !s1_go;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        is_blank    = char_reg inside {CH_SPACE, CH_TAB, CH_NL};
        is_minus_ok = (char_reg == CH_MINUS) && signed_mode_reg;
        is_plus     = (char_reg == CH_PLUS);
        is_x        = char_reg inside {CH_LX, CH_UX};
        is_dec      = char_reg inside {[CH_ZERO:CH_NINE]};
        is_lower    = char_reg inside {[CH_LA:CH_LZ]};
        is_upper    = char_reg inside {[CH_UA:CH_UZ]};
        digit_alnum = is_dec || is_lower || is_upper;
        if (is_dec)
        begin
            digit = DIGIT_BITS'(char_reg - CH_ZERO);
        end
        else if (is_lower)
        begin
            digit = DIGIT_BITS'(char_reg - CH_LA + ALPHA_OFFSET);
        end
        else
        begin
            digit = DIGIT_BITS'(char_reg - CH_UA + ALPHA_OFFSET);
        end

        first_case  = ((phase_reg == PH_SPACE) && !is_blank && !is_minus_ok && !is_plus)
                      || (phase_reg == PH_FIRST);
        auto_or_hex = (radix_reg == RADIX_AUTO) || (radix_reg == RADIX_HEX);
        prefix_zero = first_case && auto_or_hex && (char_reg == CH_ZERO);
        first_radix = (radix_reg == RADIX_AUTO) ? RADIX_DEC : radix_reg;
        use_radix   = first_case ? first_radix : act_radix_reg;
        do_digit    = (first_case && !prefix_zero)
                      || ((phase_reg == PH_ZERO) && !is_x)
                      || (phase_reg == PH_DIGITS);
        digit_ok    = (char_reg != CH_NUL) && digit_alnum && (digit < use_radix);

        acc_step    = acc_reg * VALUE_BITS'(use_radix) + VALUE_BITS'(digit);
        cnt_inc     = (cnt_reg < COUNT_LIMIT) ? cnt_reg + 1'b1 : cnt_reg;
    end

    // phase transitions
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_SPACE, PH_FIRST:
            begin
                if ((phase_reg == PH_SPACE) && is_blank)
                begin
                    phase_next = PH_SPACE;
                end
                else if ((phase_reg == PH_SPACE) && (is_minus_ok || is_plus))
                begin
                    phase_next = PH_FIRST;
                end
                else if (prefix_zero)
                begin
                    phase_next = PH_ZERO;
                end
                else
                begin
                    phase_next = digit_ok ? PH_DIGITS : PH_DONE;
                end
            end
            PH_ZERO:
            begin
                if (is_x)
                begin
                    phase_next = PH_DIGITS;
                end
                else
                begin
                    phase_next = digit_ok ? PH_DIGITS : PH_DONE;
                end
            end
            PH_DIGITS:
            begin
                phase_next = digit_ok ? PH_DIGITS : PH_DONE;
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase
    end

    // datapath updates
    always_comb
    begin
        count_inc = ((phase_reg == PH_SPACE) && (is_blank || is_minus_ok || is_plus))
                    || prefix_zero
                    || ((phase_reg == PH_ZERO) && is_x)
                    || (do_digit && digit_ok);
        acc_next  = (do_digit && digit_ok) ? acc_step : acc_reg;
        cnt_next  = count_inc ? cnt_inc : cnt_reg;
        neg_next  = neg_reg || ((phase_reg == PH_SPACE) && is_minus_ok);
        if (first_case)
        begin
            if (prefix_zero)
            begin
                act_radix_next = (radix_reg == RADIX_AUTO) ? RADIX_OCT : RADIX_HEX;
            end
            else
            begin
                act_radix_next = first_radix;
            end
        end
        else if ((phase_reg == PH_ZERO) && is_x)
        begin
            act_radix_next = RADIX_HEX;
        end
        else
        begin
            act_radix_next = act_radix_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg       <= RADIX_RESET;
            signed_mode_reg <= 1'b1;
            s1_valid_reg    <= 1'b0;
            phase_reg       <= PH_SPACE;
            acc_reg         <= '0;
            neg_reg         <= 1'b0;
            act_radix_reg   <= '0;
            cnt_reg         <= '0;
            pend_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_RADIX:       radix_reg       <= cfg_data[RADIX_BITS-1:0];
                    REG_SIGNED_MODE: signed_mode_reg <= cfg_data[0];
                    default:         radix_reg       <= radix_reg;
                endcase
            end

            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_go)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_go)
            begin
                if (eos_reg)
                begin
                    phase_reg     <= PH_SPACE;
                    acc_reg       <= '0;
                    neg_reg       <= 1'b0;
                    act_radix_reg <= '0;
                    cnt_reg       <= '0;
                end
                else
                begin
                    phase_reg     <= phase_next;
                    acc_reg       <= acc_next;
                    neg_reg       <= neg_next;
                    act_radix_reg <= act_radix_next;
                    cnt_reg       <= cnt_next;
                end
            end

            if (s1_go && eos_reg)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (pend_go)
            begin
                pend_valid_reg <= 1'b0;
            end

            if (pend_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            char_reg <= character;
            eos_reg  <= end_of_string;
        end
        if (s1_go && eos_reg)
        begin
            pend_acc_reg <= acc_next;
            pend_neg_reg <= neg_next;
            pend_cnt_reg <= cnt_next;
        end
        if (pend_go)
        begin
            value_reg  <= pend_neg_reg ? ('0 - pend_acc_reg) : pend_acc_reg;
            offset_reg <= pend_cnt_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign value      = OUT_VALUE_BITS'(value_reg);
    assign end_offset = offset_reg;

    a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= COUNT_LIMIT)
        else $error("consumed count above limit");

    a_space_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_SPACE) |-> (acc_reg == '0 && !neg_reg && act_radix_reg == '0))
        else $error("parser state not clear in whitespace phase");

    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> s1_valid_reg)
        else $error("accepted request lost at input register");

    a_refill: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_valid_reg && out_valid_reg && !out_stall) |=> out_valid_reg)
        else $error("pending result not moved to output");

    a_last_to_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_go && eos_reg) |=> pend_valid_reg)
        else $error("final character produced no pending result");

endmodule
